@@ rtl/core/trd_pkg.sv @@
// Package for the touch record decoder: status codes, register indexes,
// shared structs and default constants. No dependencies.
package trd_pkg;

    localparam int NUM_SLOTS_DEF = 10;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 12;
    localparam int COORD_W       = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_X_EXTENT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_EXTENT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y = 4'd3;

    localparam logic [1:0] TYPE_TOUCHSCREEN = 2'd1;
    localparam logic [COORD_W-1:0] EXTENT_RESET = 12'hFFF;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_BAD_SLOT  = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_SPURIOUS  = 3'd3,
        ST_OUT_RANGE = 3'd4
    } t_status;

    typedef struct packed {
        logic [COORD_W-1:0] x_extent;
        logic [COORD_W-1:0] y_extent;
        logic               mirror_x;
        logic               mirror_y;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [3:0]         slot;
        logic               press;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } t_dec;

endpackage

@@ rtl/core/trd_cfg_regs.sv @@
// Configuration register bank: extents and mirror controls.
// Depends on trd_pkg.
module trd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output trd_pkg::t_cfg                  o_cfg
);
    import trd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_extent <= EXTENT_RESET;
            r_cfg.y_extent <= EXTENT_RESET;
            r_cfg.mirror_x <= 1'b0;
            r_cfg.mirror_y <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_EXTENT: r_cfg.x_extent <= i_cfg_data[COORD_W-1:0];
                CFG_Y_EXTENT: r_cfg.y_extent <= i_cfg_data[COORD_W-1:0];
                CFG_MIRROR_X: r_cfg.mirror_x <= i_cfg_data[0];
                CFG_MIRROR_Y: r_cfg.mirror_y <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/trd_slot_state.sv @@
// Per-slot pressed bits and a running count of pressed slots.
// Depends on trd_pkg.
module trd_slot_state #(
    parameter int NUM_SLOTS = trd_pkg::NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_slot,
    input  logic       i_update,
    input  logic       i_press,
    output logic       o_pressed,
    output logic [3:0] o_count
);
    import trd_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [3:0] SLOTS_L = 4'(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_pressed;
    logic [3:0]           r_count;
    logic [3:0]           n_count;
    logic                 in_range;

    assign in_range  = i_slot < SLOTS_L;
    assign o_pressed = in_range ? r_pressed[i_slot[SLOT_W-1:0]] : 1'b0;
    assign n_count   = r_count + {3'd0, i_press} - {3'd0, o_pressed};
    assign o_count   = i_update ? n_count : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
            r_count   <= '0;
        end else if (i_update && in_range) begin
            r_pressed[i_slot[SLOT_W-1:0]] <= i_press;
            r_count                       <= n_count;
        end
    end

endmodule

@@ rtl/core/trd_check.sv @@
// Record field decode, validity checks in priority order, and axis mirroring.
// Depends on trd_pkg.
module trd_check #(
    parameter int NUM_SLOTS = trd_pkg::NUM_SLOTS_DEF
) (
    input  logic [7:0]    i_header_byte,
    input  logic [7:0]    i_coord_high_byte,
    input  logic [7:0]    i_x_low_byte,
    input  logic [7:0]    i_y_low_byte,
    input  trd_pkg::t_cfg i_cfg,
    input  logic          i_slot_pressed,
    output trd_pkg::t_dec o_dec
);
    import trd_pkg::*;

    localparam logic [3:0] SLOTS_L = 4'(NUM_SLOTS);

    logic [3:0]         slot;
    logic [1:0]         rec_type;
    logic               press;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    t_status            status;

    assign slot     = i_header_byte[3:0] - 4'd1;
    assign rec_type = i_header_byte[6:5];
    assign press    = i_header_byte[7];
    assign x        = {i_coord_high_byte[3:0], i_x_low_byte};
    assign y        = {i_coord_high_byte[7:4], i_y_low_byte};

    always_comb begin
        if (slot >= SLOTS_L) begin
            status = ST_BAD_SLOT;
        end else if (rec_type != TYPE_TOUCHSCREEN) begin
            status = ST_BAD_TYPE;
        end else if (!press && !i_slot_pressed) begin
            status = ST_SPURIOUS;
        end else if (x > i_cfg.x_extent || y > i_cfg.y_extent) begin
            status = ST_OUT_RANGE;
        end else begin
            status = ST_ACCEPTED;
        end
    end

    always_comb begin
        o_dec.status = status;
        o_dec.slot   = slot;
        o_dec.press  = press;
        o_dec.pos_x  = x;
        o_dec.pos_y  = y;
        if (status == ST_ACCEPTED && i_cfg.mirror_x) begin
            o_dec.pos_x = i_cfg.x_extent - x;
        end
        if (status == ST_ACCEPTED && i_cfg.mirror_y) begin
            o_dec.pos_y = i_cfg.y_extent - y;
        end
    end

endmodule

@@ rtl/core/touch_record_decoder_top.sv @@
// Touch record decoder top: input register, check logic, slot state, result register.
// Depends on trd_pkg, trd_cfg_regs, trd_check, trd_slot_state.
// Path: input register, then result register; a record moves on unless the output stalls.
// Throughput: one record per cycle if not stalled; the slot bit update is a read-modify-write.
// Reset: synchronous active low; clears valids, slot bits, count; extents to 4095, mirrors off.
module touch_record_decoder_top #(
    parameter int NUM_SLOTS = trd_pkg::NUM_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_header_byte,
    input  logic [7:0]                     i_coord_high_byte,
    input  logic [7:0]                     i_x_low_byte,
    input  logic [7:0]                     i_y_low_byte,
    input  logic [7:0]                     i_contact_width,
    input  logic [7:0]                     i_contact_strength,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [3:0]                     o_slot,
    output logic                           o_is_pressed,
    output logic [11:0]                    o_pos_x,
    output logic [11:0]                    o_pos_y,
    output logic [7:0]                     o_width_out,
    output logic [7:0]                     o_strength_out,
    output logic [3:0]                     o_active_count
);
    import trd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_hdr, r_hi, r_xl, r_yl, r_wid, r_str;

    logic       r_out_valid;
    t_dec       r_dec;
    logic [7:0] r_wid_out, r_str_out;
    logic [3:0] r_count_out;

    t_cfg       cfg;
    t_dec       dec;
    logic       slot_pressed;
    logic [3:0] count_after;
    logic       advance;
    logic       update;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign update     = advance && (dec.status == ST_ACCEPTED);

    trd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    trd_check #(.NUM_SLOTS(NUM_SLOTS)) u_check (
        .i_header_byte     (r_hdr),
        .i_coord_high_byte (r_hi),
        .i_x_low_byte      (r_xl),
        .i_y_low_byte      (r_yl),
        .i_cfg             (cfg),
        .i_slot_pressed    (slot_pressed),
        .o_dec             (dec)
    );

    trd_slot_state #(.NUM_SLOTS(NUM_SLOTS)) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_slot    (dec.slot),
        .i_update  (update),
        .i_press   (dec.press),
        .o_pressed (slot_pressed),
        .o_count   (count_after)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_hdr <= i_header_byte;
            r_hi  <= i_coord_high_byte;
            r_xl  <= i_x_low_byte;
            r_yl  <= i_y_low_byte;
            r_wid <= i_contact_width;
            r_str <= i_contact_strength;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_dec       <= dec;
            r_wid_out   <= r_wid;
            r_str_out   <= r_str;
            r_count_out <= count_after;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_dec.status;
    assign o_slot         = r_dec.slot;
    assign o_is_pressed   = r_dec.press;
    assign o_pos_x        = r_dec.pos_x;
    assign o_pos_y        = r_dec.pos_y;
    assign o_width_out    = r_wid_out;
    assign o_strength_out = r_str_out;
    assign o_active_count = r_count_out;

endmodule

@@ rtl/core/trd_checker.sv @@
// Port-level checker for the touch record decoder, bound to the top level.
// Depends on trd_pkg and touch_record_decoder_top.
module trd_checker #(
    parameter int NUM_SLOTS = trd_pkg::NUM_SLOTS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [3:0]  o_slot,
    input logic [11:0] o_pos_x,
    input logic [3:0]  o_active_count
);
    import trd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_slot) && $stable(o_pos_x) && $stable(o_active_count))
        else $error("result changed while stalled");

    a_bad_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BAD_SLOT) |-> (o_slot >= NUM_SLOTS))
        else $error("bad slot status on an in-range slot");

    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_BAD_SLOT) |-> (o_slot < NUM_SLOTS))
        else $error("out-of-range slot passed the slot check");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_active_count <= NUM_SLOTS))
        else $error("active count exceeds slot count");

endmodule

bind touch_record_decoder_top trd_checker #(.NUM_SLOTS(NUM_SLOTS)) u_trd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_slot         (o_slot),
    .o_pos_x        (o_pos_x),
    .o_active_count (o_active_count)
);
